### src/dtwg_pkg.sv
// Shared constants, register codes and types of the table waveform generator.
package dtwg_pkg;

    localparam int DEF_TABLE_ADDR_BITS = 12;
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_CODE_BITS       = 12;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;

    localparam int FREQ_BITS   = 19;
    localparam int CORR_BITS   = 16;
    localparam int GAIN_BITS   = 20;
    localparam int OFFSET_BITS = 13;
    localparam int CLAMP_BITS  = 12;
    localparam int VOLTS_BITS  = 16;

    // 6442.450944 in Q16, truncated
    localparam int STEP_Q16_BITS = 29;
    localparam logic [STEP_Q16_BITS-1:0] STEP_Q16 = 29'd422212465;
    localparam int STEP_PROD_BITS = FREQ_BITS + STEP_Q16_BITS;
    localparam int STEP_FRAC_BITS = 16;
    localparam int STEP_BITS      = STEP_PROD_BITS - STEP_FRAC_BITS;

    localparam logic [GAIN_BITS-1:0]  GAIN_RESET     = 20'd317750;
    localparam logic [CLAMP_BITS-1:0] CODE_MAX_RESET = 12'd4095;
    localparam logic [CLAMP_BITS-1:0] CODE_MIN_RESET = 12'd0;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FREQUENCY_HZ,
        CFG_PHASE_CORRECTION,
        CFG_GAIN,
        CFG_CODE_OFFSET,
        CFG_CODE_MAX,
        CFG_CODE_MIN
    } cfg_index_t;

    typedef struct packed {
        logic        [GAIN_BITS-1:0]   gain;
        logic signed [OFFSET_BITS-1:0] offset;
        logic        [CLAMP_BITS-1:0]  code_max;
        logic        [CLAMP_BITS-1:0]  code_min;
    } conv_cfg_t;

endpackage

### src/dtwg_conv.sv
// Voltage to converter code pipeline: scale, truncate toward zero, offset, clamp.
module dtwg_conv #(
    parameter int TABLE_ADDR_BITS = dtwg_pkg::DEF_TABLE_ADDR_BITS,
    parameter int CODE_BITS       = dtwg_pkg::DEF_CODE_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load_valid,
    input  logic [TABLE_ADDR_BITS-1:0]            load_index,
    input  logic signed [dtwg_pkg::VOLTS_BITS-1:0] load_volts,
    input  dtwg_pkg::conv_cfg_t                   cfg,
    output logic                                  wr_en,
    output logic [TABLE_ADDR_BITS-1:0]            wr_addr,
    output logic [CODE_BITS-1:0]                  wr_code
);
    import dtwg_pkg::*;

    localparam int PROD_BITS = VOLTS_BITS + GAIN_BITS;
    localparam int SHIFT     = 20;
    localparam int SUM_BITS  = VOLTS_BITS + 1;

    logic signed [PROD_BITS:0]     prod_full;
    logic                          valid_reg;
    logic [TABLE_ADDR_BITS-1:0]    index_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [OFFSET_BITS-1:0] offset_reg;
    logic [CLAMP_BITS-1:0]         max_reg;
    logic [CLAMP_BITS-1:0]         min_reg;

    logic signed [PROD_BITS-1:0]   adj;
    logic signed [VOLTS_BITS-1:0]  quot;
    logic signed [SUM_BITS-1:0]    sum;
    logic signed [SUM_BITS-1:0]    max_ext;
    logic signed [SUM_BITS-1:0]    min_ext;
    logic [CLAMP_BITS-1:0]         code_clamped;
    logic [CODE_BITS+CLAMP_BITS-1:0] code_wide;

    assign prod_full = load_volts * $signed({1'b0, cfg.gain});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= load_valid;
        end
        if (load_valid) begin
            index_reg  <= load_index;
            prod_reg   <= prod_full[PROD_BITS-1:0];
            offset_reg <= cfg.offset;
            max_reg    <= cfg.code_max;
            min_reg    <= cfg.code_min;
        end
    end

    always_comb begin
        // bias negative products so the arithmetic shift rounds toward zero
        adj     = prod_reg + (prod_reg[PROD_BITS-1]
                              ? $signed(PROD_BITS'((1 << SHIFT) - 1))
                              : $signed(PROD_BITS'(0)));
        quot    = adj[PROD_BITS-1 -: VOLTS_BITS];
        sum     = {quot[VOLTS_BITS-1], quot}
                  + {{(SUM_BITS-OFFSET_BITS){offset_reg[OFFSET_BITS-1]}}, offset_reg};
        max_ext = $signed({{(SUM_BITS-CLAMP_BITS){1'b0}}, max_reg});
        min_ext = $signed({{(SUM_BITS-CLAMP_BITS){1'b0}}, min_reg});
        if (sum > max_ext) begin
            code_clamped = max_reg;
        end else if (sum < min_ext) begin
            code_clamped = min_reg;
        end else begin
            code_clamped = sum[CLAMP_BITS-1:0];
        end
        code_wide = {{CODE_BITS{1'b0}}, code_clamped};
    end

    assign wr_en   = valid_reg;
    assign wr_addr = index_reg;
    assign wr_code = code_wide[CODE_BITS-1:0];

endmodule

### src/dtwg_wave_mem.sv
// Waveform table memory: one write port, one registered read port with write forwarding.
module dtwg_wave_mem #(
    parameter int TABLE_ADDR_BITS = dtwg_pkg::DEF_TABLE_ADDR_BITS,
    parameter int CODE_BITS       = dtwg_pkg::DEF_CODE_BITS
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [TABLE_ADDR_BITS-1:0] wr_addr,
    input  logic [CODE_BITS-1:0]       wr_data,
    input  logic                       rd_en,
    input  logic [TABLE_ADDR_BITS-1:0] rd_addr,
    output logic [CODE_BITS-1:0]       rd_data
);
    import dtwg_pkg::*;

    localparam int DEPTH = 1 << TABLE_ADDR_BITS;

    logic [CODE_BITS-1:0] mem [DEPTH];
    logic [CODE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // take the word being written when it lands on the entry read this cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/dds_table_waveform_generator_top.sv
// Top level of the table-driven DDS waveform generator.
//
// The block takes one word per clock cycle on its input channel, loads and
// ticks alike, with no gaps while the result buffer has room, and no clearing
// pass after reset. A load word (op = 0) converts its Q4.12 voltage into a
// converter code and writes it into the waveform table; the multiplier of that
// conversion sits in its own stage. A tick word (op = 1) advances the phase
// accumulator by the phase step and reads the table at the top TABLE_ADDR_BITS
// bits of the new phase through the single synchronous read port; its code
// then passes the read register and the result buffer. A tick that directly
// follows a load of the same entry sees the new code. Results queue in a
// two-word buffer, so input acceptance continues while a result waits to be
// taken. The table holds whatever was last loaded; load every entry before the
// first tick. The user must write the configuration registers (frequency,
// correction, gain, offset, clamp bounds) only while idle; the block does not
// enforce this. The frequency is multiplied into the phase step at write time.
module dds_table_waveform_generator_top #(
    parameter int TABLE_ADDR_BITS = dtwg_pkg::DEF_TABLE_ADDR_BITS,
    parameter int PHASE_BITS      = dtwg_pkg::DEF_PHASE_BITS,
    parameter int CODE_BITS       = dtwg_pkg::DEF_CODE_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [dtwg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [dtwg_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    // input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_op,
    input  logic [TABLE_ADDR_BITS-1:0]             s_sample_index,
    input  logic signed [dtwg_pkg::VOLTS_BITS-1:0] s_sample_volts,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [CODE_BITS-1:0]                   m_dac_code
);
    import dtwg_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [STEP_BITS-1:0]          step_base_reg;   // (freq * STEP_Q16) >> 16
    logic signed [CORR_BITS-1:0]   corr_reg;
    conv_cfg_t                     conv_cfg_reg;
    logic [STEP_PROD_BITS-1:0]     step_prod;

    assign step_prod = STEP_PROD_BITS'(cfg_wdata[FREQ_BITS-1:0]) * STEP_PROD_BITS'(STEP_Q16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_base_reg         <= '0;
            corr_reg              <= '0;
            conv_cfg_reg.gain     <= GAIN_RESET;
            conv_cfg_reg.offset   <= '0;
            conv_cfg_reg.code_max <= CODE_MAX_RESET;
            conv_cfg_reg.code_min <= CODE_MIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_FREQUENCY_HZ: begin
                    step_base_reg <= step_prod[STEP_PROD_BITS-1 -: STEP_BITS];
                end
                CFG_PHASE_CORRECTION: begin
                    corr_reg <= cfg_wdata[CORR_BITS-1:0];
                end
                CFG_GAIN: begin
                    conv_cfg_reg.gain <= cfg_wdata[GAIN_BITS-1:0];
                end
                CFG_CODE_OFFSET: begin
                    conv_cfg_reg.offset <= cfg_wdata[OFFSET_BITS-1:0];
                end
                CFG_CODE_MAX: begin
                    conv_cfg_reg.code_max <= cfg_wdata[CLAMP_BITS-1:0];
                end
                CFG_CODE_MIN: begin
                    conv_cfg_reg.code_min <= cfg_wdata[CLAMP_BITS-1:0];
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input acceptance
    // ---------------------------------------------------------------
    logic       accept;
    logic       load_acc;
    logic       tick_acc;
    logic       rd_valid_reg;        // tick whose table read is in flight
    logic [1:0] buf_cnt_reg;
    logic [1:0] buf_cnt_next;
    logic       pop;
    logic       busy_full;

    assign pop       = m_valid && m_ready;
    // at most two ticks between read port and result buffer
    assign busy_full = (buf_cnt_reg == 2'd2) || ((buf_cnt_reg == 2'd1) && rd_valid_reg);
    assign s_ready   = !busy_full || pop;
    assign accept    = s_valid && s_ready;
    assign load_acc  = accept && (s_op == OP_LOAD);
    assign tick_acc  = accept && (s_op == OP_TICK);

    // ---------------------------------------------------------------
    // Phase accumulator
    // ---------------------------------------------------------------
    logic [PHASE_BITS-1:0]           phase_reg;
    logic [PHASE_BITS-1:0]           phase_next;
    logic [PHASE_BITS+STEP_BITS-1:0] step_base_wide;
    logic [PHASE_BITS+CORR_BITS-1:0] corr_wide;

    // zero-extend the step and sign-extend the trim, then wrap to the phase width
    assign step_base_wide = {{PHASE_BITS{1'b0}}, step_base_reg};
    assign corr_wide      = {{PHASE_BITS{corr_reg[CORR_BITS-1]}}, corr_reg};
    assign phase_next     = phase_reg + step_base_wide[PHASE_BITS-1:0]
                            + corr_wide[PHASE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (tick_acc) begin
            phase_reg <= phase_next;
        end
    end

    // ---------------------------------------------------------------
    // Load conversion and waveform table
    // ---------------------------------------------------------------
    logic                       wr_en;
    logic [TABLE_ADDR_BITS-1:0] wr_addr;
    logic [CODE_BITS-1:0]       wr_code;
    logic [CODE_BITS-1:0]       rd_data;

    dtwg_conv #(
        .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
        .CODE_BITS      (CODE_BITS)
    ) u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_valid(load_acc),
        .load_index(s_sample_index),
        .load_volts(s_sample_volts),
        .cfg       (conv_cfg_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_code   (wr_code)
    );

    dtwg_wave_mem #(
        .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
        .CODE_BITS      (CODE_BITS)
    ) u_wave_mem (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_code),
        .rd_en  (tick_acc),
        .rd_addr(phase_next[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= tick_acc;
        end
    end

    // ---------------------------------------------------------------
    // Two-word result buffer: head drives the result channel
    // ---------------------------------------------------------------
    logic [CODE_BITS-1:0] head_reg;
    logic [CODE_BITS-1:0] head_next;
    logic [CODE_BITS-1:0] tail_reg;
    logic [CODE_BITS-1:0] tail_next;

    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        buf_cnt_next = buf_cnt_reg;
        if (pop) begin
            if (buf_cnt_reg == 2'd2) begin
                // advance the tail into the head, refill the tail
                head_next = tail_reg;
                if (rd_valid_reg) begin
                    tail_next = rd_data;
                end else begin
                    buf_cnt_next = 2'd1;
                end
            end else begin
                if (rd_valid_reg) begin
                    head_next = rd_data;
                end else begin
                    buf_cnt_next = 2'd0;
                end
            end
        end else if (rd_valid_reg) begin
            if (buf_cnt_reg == 2'd0) begin
                head_next    = rd_data;
                buf_cnt_next = 2'd1;
            end else begin
                tail_next    = rd_data;
                buf_cnt_next = 2'd2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_cnt_reg <= 2'd0;
        end else begin
            buf_cnt_reg <= buf_cnt_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_valid    = (buf_cnt_reg != 2'd0);
    assign m_dac_code = head_reg;

endmodule

### tb/dds_table_waveform_generator_top_tb.sv
// Self-checking testbench of the table-driven DDS waveform generator: directed and random words.
`timescale 1ns / 100ps

module dds_table_waveform_generator_top_tb;
    import dtwg_pkg::*;

    localparam int ADDR_BITS     = DEF_TABLE_ADDR_BITS;
    localparam int PH_BITS       = DEF_PHASE_BITS;
    localparam int CODE_W        = DEF_CODE_BITS;
    localparam int TABLE_DEPTH   = 1 << ADDR_BITS;
    // lets the last load land in the table and the tick pipe empty; allow some slack
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    // register indexes past the end of the list; the block drops these writes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic        [FREQ_BITS-1:0]   freq;
        logic signed [CORR_BITS-1:0]   corr;
        logic        [GAIN_BITS-1:0]   gain;
        logic signed [OFFSET_BITS-1:0] offset;
        logic        [CLAMP_BITS-1:0]  code_max;
        logic        [CLAMP_BITS-1:0]  code_min;
    } dds_settings_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          cfg_wr_en      = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_wdata      = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic                          s_op           = OP_LOAD;
    logic [ADDR_BITS-1:0]          s_sample_index = '0;
    logic signed [VOLTS_BITS-1:0]  s_sample_volts = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [CODE_W-1:0]             m_dac_code;

    // predictor state: live settings, phase and a shadow of the waveform table
    dds_settings_t     live_cfg;
    logic [PH_BITS-1:0] phase_acc;
    logic [CODE_W-1:0] shadow_table [TABLE_DEPTH];
    bit                entry_loaded [TABLE_DEPTH];
    logic [CODE_W-1:0] pending_codes [$];

    int                mismatches     = 0;
    int                burst_left     = 0;
    bit                gaps_on        = 1'b0;
    int                hold_req       = 0;
    int                hold_left      = 0;
    int                rx_seg_left    = 0;
    rx_mode_t          rx_mode        = RX_FREE;
    logic [CODE_W-1:0] want_code;

    dds_table_waveform_generator_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_sample_index (s_sample_index),
        .s_sample_volts (s_sample_volts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dac_code     (m_dac_code)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Scale Q4.12 volts by gain/2^20 (truncate toward zero), add offset, clamp.
    // Upper bound tested first; inverted bounds give code_max above it, else code_min.
    function automatic logic [CODE_W-1:0] volts_to_code(logic signed [VOLTS_BITS-1:0] volts);
        longint scaled;
        scaled = (longint'(volts) * longint'(live_cfg.gain)) / 1048576
                 + longint'(live_cfg.offset);
        if (scaled > longint'(live_cfg.code_max))
            scaled = longint'(live_cfg.code_max);
        else if (scaled < longint'(live_cfg.code_min))
            scaled = longint'(live_cfg.code_min);
        return scaled[CODE_W-1:0];
    endfunction

    // Truncated frequency product in Q16 plus the signed trim, modulo 2^PH_BITS.
    function automatic logic [PH_BITS-1:0] phase_step();
        logic [63:0] prod;
        prod = (64'(live_cfg.freq) * 64'(STEP_Q16)) >> STEP_FRAC_BITS;
        return prod[PH_BITS-1:0] + PH_BITS'(live_cfg.corr);
    endfunction

    function automatic logic [ADDR_BITS-1:0] next_tick_entry();
        logic [PH_BITS-1:0] nxt;
        nxt = phase_acc + phase_step();
        return nxt[PH_BITS-1 -: ADDR_BITS];
    endfunction

    function automatic dds_settings_t make_settings(int unsigned freq, int corr,
                                                    int unsigned gain, int offset,
                                                    int unsigned code_max,
                                                    int unsigned code_min);
        dds_settings_t s;
        s.freq     = FREQ_BITS'(freq);
        s.corr     = CORR_BITS'(corr);
        s.gain     = GAIN_BITS'(gain);
        s.offset   = OFFSET_BITS'(offset);
        s.code_max = CLAMP_BITS'(code_max);
        s.code_min = CLAMP_BITS'(code_min);
        return s;
    endfunction

    // Mostly uniform, with the range ends picked often.
    function automatic int unsigned edge_or_any(int unsigned lo, int unsigned hi);
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return lo;
        if (pick == 1)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    function automatic dds_settings_t random_settings();
        dds_settings_t s;
        s.freq     = FREQ_BITS'(edge_or_any(0, (1 << FREQ_BITS) - 1));
        s.corr     = CORR_BITS'(edge_or_any(0, (1 << CORR_BITS) - 1) - 32768);
        s.gain     = GAIN_BITS'(edge_or_any(0, (1 << GAIN_BITS) - 1));
        s.offset   = OFFSET_BITS'(edge_or_any(0, (1 << OFFSET_BITS) - 1) - 4096);
        s.code_max = CLAMP_BITS'(edge_or_any(0, (1 << CLAMP_BITS) - 1));
        s.code_min = CLAMP_BITS'(edge_or_any(0, (1 << CLAMP_BITS) - 1));
        return s;
    endfunction

    function automatic logic signed [VOLTS_BITS-1:0] random_volts();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return VOLTS_BITS'($urandom_range(0, 8191) - 4096);
            default: return VOLTS_BITS'($urandom());
        endcase
    endfunction

    function automatic void note_failure(string what, logic [CODE_W-1:0] want,
                                         logic [CODE_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected dac_code %0d, got %0d", $realtime, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word and hold it until accepted, then update the predictor.
    // Valid is left high on return: the caller either sends the next word in
    // the same step or drops valid in that step through wait_drained.
    task automatic send_word(logic op, logic [ADDR_BITS-1:0] idx,
                             logic signed [VOLTS_BITS-1:0] volts);
        int gap;
        if (gaps_on && burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_sample_index <= idx;
        s_sample_volts <= volts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        if (op == OP_LOAD) begin
            shadow_table[idx] = volts_to_code(volts);
            entry_loaded[idx] = 1'b1;
        end else begin
            phase_acc = phase_acc + phase_step();
            pending_codes.push_back(shadow_table[phase_acc[PH_BITS-1 -: ADDR_BITS]]);
        end
    endtask

    // Tick, loading the entry it will land on first if it was never written.
    task automatic issue_tick();
        logic [ADDR_BITS-1:0] nxt;
        nxt = next_tick_entry();
        if (!entry_loaded[nxt])
            send_word(OP_LOAD, nxt, random_volts());
        send_word(OP_TICK, ADDR_BITS'($urandom()), VOLTS_BITS'($urandom()));
    endtask

    // Load the entry the next tick reads, then tick right behind it.
    task automatic probe_code(logic signed [VOLTS_BITS-1:0] volts);
        send_word(OP_LOAD, next_tick_entry(), volts);
        send_word(OP_TICK, ADDR_BITS'($urandom()), VOLTS_BITS'($urandom()));
    endtask

    // Drop valid, wait for every pending result, then let the pipe settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all registers, spare indexes first; call only while idle.
    task automatic write_settings(dds_settings_t s);
        logic [CFG_DATA_BITS-1:0] words [8];
        words[CFG_FREQUENCY_HZ]     = CFG_DATA_BITS'(s.freq);
        words[CFG_PHASE_CORRECTION] = CFG_DATA_BITS'(s.corr);
        words[CFG_GAIN]             = CFG_DATA_BITS'(s.gain);
        words[CFG_CODE_OFFSET]      = CFG_DATA_BITS'(s.offset);
        words[CFG_CODE_MAX]         = CFG_DATA_BITS'(s.code_max);
        words[CFG_CODE_MIN]         = CFG_DATA_BITS'(s.code_min);
        words[CFG_SPARE_A]          = CFG_DATA_BITS'($urandom());
        words[CFG_SPARE_B]          = CFG_DATA_BITS'($urandom());
        for (int i = 7; i >= 0; i--) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_INDEX_BITS'(i);
            cfg_wdata <= words[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        live_cfg = s;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each accepted word, then pick the next ready value
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_codes.size() == 0) begin
                note_failure("result with nothing pending", '0, m_dac_code);
            end else begin
                want_code = pending_codes.pop_front();
                if (m_dac_code !== want_code)
                    note_failure("dac_code mismatch", want_code, m_dac_code);
            end
        end
        // a long hold-off request takes priority over the stall pattern
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req > 0) begin
            hold_left = hold_req - 1;
            hold_req  = 0;
            m_ready <= 1'b0;
        end else begin
            if (rx_seg_left <= 0) begin
                rx_mode     = rx_mode_t'($urandom_range(0, 2));
                rx_seg_left = $urandom_range(4, 40);
            end
            rx_seg_left--;
            case (rx_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: step is zero, so every tick reads entry zero. Probe the
    // volts extremes and one volt through the reset gain.
    task automatic test_reset_defaults();
        gaps_on = 1'b0;
        probe_code(16'sh7FFF);
        probe_code(16'sh8000);
        probe_code(16'sh1000);
        // write the top entry too
        send_word(OP_LOAD, '1, 16'sh7FFF);
        wait_drained();
    endtask

    // Conversion corners with a zero step, each load followed at once by a
    // tick of the same entry.
    task automatic test_conversion();
        gaps_on = 1'b0;
        // full gain: top volts clamp high; -1 truncates toward zero, not down
        write_settings(make_settings(0, 0, (1 << GAIN_BITS) - 1, 100, 4095, 0));
        probe_code(16'sh7FFF);
        probe_code(16'shFFFF);
        wait_drained();
        // zero gain, most negative offset: pinned at the lower bound
        write_settings(make_settings(0, 0, 0, -4096, 4095, 7));
        probe_code(16'sh8000);
        probe_code(16'sh0001);
        wait_drained();
        // inverted bounds with the top offset: upper test wins, else lower bound
        write_settings(make_settings(0, 0, GAIN_RESET, 4095, 1000, 3000));
        probe_code(16'sh7FFF);
        probe_code(16'sh8000);
        wait_drained();
    endtask

    // Largest step with both trim extremes, and a negative step that wraps.
    task automatic test_phase_extremes();
        dds_settings_t rows [3];
        gaps_on = 1'b0;
        rows[0] = make_settings((1 << FREQ_BITS) - 1, 32767, GAIN_RESET, 0, 4095, 0);
        rows[1] = make_settings((1 << FREQ_BITS) - 1, -32768, GAIN_RESET, 0, 4095, 0);
        rows[2] = make_settings(0, -32768, GAIN_RESET, 0, 4095, 0);
        foreach (rows[r]) begin
            write_settings(rows[r]);
            issue_tick();
            issue_tick();
            wait_drained();
        end
    endtask

    // Random settings per phase; ticks and loads with random content, some
    // loads aimed at the entry the next tick reads.
    task automatic test_random_traffic(int phases, int words_per_phase);
        int pick;
        repeat (phases) begin
            write_settings(random_settings());
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            repeat (words_per_phase) begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    issue_tick();
                else if (pick < 8)
                    send_word(OP_LOAD, ADDR_BITS'($urandom()), random_volts());
                else
                    send_word(OP_LOAD, next_tick_entry(), random_volts());
            end
            wait_drained();
        end
    endtask

    // Hold the receiver off while ticks keep coming so the block stalls its
    // input; pause the sender until every result is in, then go again.
    task automatic test_backpressure();
        write_settings(random_settings());
        gaps_on  = 1'b0;
        hold_req = 300;
        repeat (40) issue_tick();
        // sender pause: nothing more until all results have come
        wait_drained();
        gaps_on    = 1'b1;
        burst_left = 0;
        repeat (30) issue_tick();
        hold_req = 120;
        repeat (30) issue_tick();
        wait_drained();
    endtask

    initial begin
        live_cfg  = make_settings(0, 0, GAIN_RESET, 0, CODE_MAX_RESET, CODE_MIN_RESET);
        phase_acc = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_conversion();
        test_phase_extremes();
        test_random_traffic(5, 50);
        test_backpressure();

        // catch any stray result after the last expected one
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
src/dtwg_pkg.sv
src/dtwg_conv.sv
src/dtwg_wave_mem.sv
src/dds_table_waveform_generator_top.sv
tb/dds_table_waveform_generator_top_tb.sv
